@@ hdl/dts_pkg.sv @@
`timescale 1ns / 1ps

package dts_pkg;

    localparam int POSITION_BITS = 16;
    localparam int LENGTH_BITS   = 8;
    localparam int CHAR_BITS     = 8;
    localparam int KIND_BITS     = 4;
    localparam int CODE_BITS     = 3;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

    // character codes
    localparam logic [CHAR_BITS-1:0] CH_SEMI    = 8'h3B;
    localparam logic [CHAR_BITS-1:0] CH_LPAREN  = 8'h28;
    localparam logic [CHAR_BITS-1:0] CH_RPAREN  = 8'h29;
    localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_BITS-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CH_COLON   = 8'h3A;
    localparam logic [CHAR_BITS-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [CHAR_BITS-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [CHAR_BITS-1:0] CH_RBRACE  = 8'h7D;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_E = 8'h65;
    localparam logic [CHAR_BITS-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_UNDER   = 8'h5F;

    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_ASSIGN  = 3'd3,
        MODE_SEP     = 3'd4,
        MODE_OP      = 3'd5,
        MODE_COMMENT = 3'd6,
        MODE_ERROR   = 3'd7
    } mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_IDENT  = 4'd0,
        KIND_NUMBER = 4'd1,
        KIND_ASSIGN = 4'd2,
        KIND_LPAREN = 4'd3,
        KIND_RPAREN = 4'd4,
        KIND_SEMI   = 4'd5,
        KIND_PLUS   = 4'd6,
        KIND_MINUS  = 4'd7,
        KIND_STAR   = 4'd8,
        KIND_SLASH  = 4'd9,
        KIND_END    = 4'd10,
        KIND_ERROR  = 4'd11
    } kind_t;

    typedef enum logic [CODE_BITS-1:0] {
        ERR_NONE      = 3'd0,
        ERR_START     = 3'd1,
        ERR_IDENT     = 3'd2,
        ERR_COLON     = 3'd3,
        ERR_NUMBER    = 3'd4,
        ERR_SEPARATOR = 3'd5,
        ERR_OPERATOR  = 3'd6,
        ERR_COMMENT   = 3'd7
    } err_t;

    typedef struct packed {
        kind_t                    kind;
        logic [POSITION_BITS-1:0] start;
        logic [LENGTH_BITS-1:0]   length;
        err_t                     code;
        logic                     last;
    } result_t;

    // outcome of the shared transition out of start/separator/operator modes
    typedef struct packed {
        logic  ok;
        logic  load;
        mode_t mode;
        kind_t kind;
    } start_t;

    function automatic logic name_start_char(logic [CHAR_BITS-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
    endfunction

    function automatic logic dec_digit(logic [CHAR_BITS-1:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_space(logic [CHAR_BITS-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
    endfunction

    function automatic logic is_op(logic [CHAR_BITS-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

    function automatic kind_t op_kind(logic [CHAR_BITS-1:0] c);
        kind_t k;
        case (c)
            CH_PLUS:  k = KIND_PLUS;
            CH_MINUS: k = KIND_MINUS;
            CH_STAR:  k = KIND_STAR;
            default:  k = KIND_SLASH;
        endcase
        return k;
    endfunction

    function automatic kind_t sep_kind(logic [CHAR_BITS-1:0] c);
        kind_t k;
        case (c)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            default:   k = KIND_SEMI;
        endcase
        return k;
    endfunction

    function automatic start_t from_start(logic [CHAR_BITS-1:0] c, logic allow_semi);
        start_t r;
        r.ok   = 1'b1;
        r.load = 1'b1;
        r.mode = MODE_START;
        r.kind = KIND_IDENT;
        if (name_start_char(c)) begin
            r.mode = MODE_IDENT;
            r.kind = KIND_IDENT;
        end else if (dec_digit(c)) begin
            r.mode = MODE_NUMBER;
            r.kind = KIND_NUMBER;
        end else if (c == CH_LPAREN || c == CH_RPAREN || (c == CH_SEMI && allow_semi)) begin
            r.mode = MODE_SEP;
            r.kind = sep_kind(c);
        end else if (is_op(c)) begin
            r.mode = MODE_OP;
            r.kind = op_kind(c);
        end else if (c == CH_LBRACE) begin
            r.load = 1'b0;
            r.mode = MODE_COMMENT;
        end else if (is_space(c)) begin
            r.load = 1'b0;
            r.mode = MODE_START;
        end else begin
            r.ok   = 1'b0;
            r.load = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ hdl/dts_char_if.sv @@
`timescale 1ns / 1ps

interface dts_char_if;
    logic                           valid;
    logic                           ready;
    logic [dts_pkg::CHAR_BITS-1:0]  input_char;
    logic                           end_of_input;

    modport source (output valid, output input_char, output end_of_input, input ready);
    modport sink   (input valid, input input_char, input end_of_input, output ready);
endinterface

@@ hdl/dts_token_if.sv @@
`timescale 1ns / 1ps

interface dts_token_if;
    logic                               valid;
    logic                               ready;
    logic [dts_pkg::KIND_BITS-1:0]      token_kind;
    logic [dts_pkg::POSITION_BITS-1:0]  token_start;
    logic [dts_pkg::LENGTH_BITS-1:0]    token_length;
    logic [dts_pkg::CODE_BITS-1:0]      error_code;
    logic                               last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output error_code, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input error_code, input last_of_run,
                    output ready);
endinterface

@@ hdl/dfa_token_scanner.sv @@
`timescale 1ns / 1ps
// dfa_token_scanner
// Byte-serial lexer. char_chan carries one source byte (or the end marker)
// per transfer; token_chan carries one token result per transfer
// (kind, start offset, length, error code, last_of_run flag).
// Path: a transferred byte is held in the input register and scanned by
// the scanner step, which writes its 0..2 results into a 4-entry result
// queue; the oldest queued result is offered on token_chan.
// Throughput: one byte per cycle as long as the token side keeps up. The
// limit is the token port, one result per cycle: a byte that yields two
// results (a pending separator/operator plus an error, or a flush or an
// error plus the end token) needs two transfers on the output side.
// Stall: the scanner step fires only when the queue has room for two
// results; otherwise the byte waits in the input register and char_chan.ready
// drops. Results are never dropped or reordered.
// Reset: rst_n (async, active low) empties the queue and the input register
// and puts the automaton in start mode at offset 0. The end marker does the
// same to the automaton state after emitting its results.

module dfa_token_scanner
(
    input  logic                clk,
    input  logic                rst_n,
    dts_char_if.sink            char_chan,
    dts_token_if.source         token_chan
);

    // ---------------- input register ----------------
    logic                               in_valid_reg;
    logic [dts_pkg::CHAR_BITS-1:0]      in_char_reg;
    logic                               in_eoi_reg;
    logic                               step;       // scanner consumes the held byte

    // ---------------- automaton state ----------------
    dts_pkg::mode_t                     mode_reg, mode_next;
    logic [dts_pkg::POSITION_BITS-1:0]  pos_reg, pos_next;
    logic [dts_pkg::POSITION_BITS-1:0]  pstart_reg, pstart_next;
    logic [dts_pkg::LENGTH_BITS-1:0]    plen_reg, plen_next;
    dts_pkg::kind_t                     pkind_reg, pkind_next;

    // ---------------- result queue ----------------
    dts_pkg::result_t                   fifo_mem [dts_pkg::FIFO_DEPTH];
    logic [dts_pkg::FIFO_PTR_BITS-1:0]  rd_ptr_reg, wr_ptr_reg;
    logic [dts_pkg::FIFO_CNT_BITS-1:0]  count_reg;
    logic                               pop;

    // ---------------- scan step outputs ----------------
    dts_pkg::result_t                   res_a, res_b;
    logic [1:0]                         res_n;
    dts_pkg::start_t                    fs_any, fs_nosemi;
    logic                               num_ext, ident_ext;
    dts_pkg::result_t                   pending_res;

    // step only when the queue can absorb a two-result byte
    assign step = in_valid_reg &&
                  (count_reg <= dts_pkg::FIFO_CNT_BITS'(dts_pkg::FIFO_DEPTH - 2));
    assign char_chan.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_chan.ready)
        begin
            in_valid_reg <= char_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_chan.ready && char_chan.valid)
        begin
            in_char_reg <= char_chan.input_char;
            in_eoi_reg  <= char_chan.end_of_input;
        end
    end

    // ---------------- scanner step ----------------
    assign fs_any    = dts_pkg::from_start(in_char_reg, 1'b1);
    assign fs_nosemi = dts_pkg::from_start(in_char_reg, 1'b0);
    assign ident_ext = dts_pkg::dec_digit(in_char_reg) || dts_pkg::name_start_char(in_char_reg);
    assign num_ext   = dts_pkg::dec_digit(in_char_reg) || in_char_reg == dts_pkg::CH_DOT ||
                       in_char_reg == dts_pkg::CH_LOWER_E || in_char_reg == dts_pkg::CH_PLUS ||
                       in_char_reg == dts_pkg::CH_MINUS;

    always_comb
    begin
        pending_res.kind   = pkind_reg;
        pending_res.start  = pstart_reg;
        pending_res.length = plen_reg;
        pending_res.code   = dts_pkg::ERR_NONE;
        pending_res.last   = 1'b0;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        pkind_next  = pkind_reg;
        res_a       = pending_res;
        res_b       = pending_res;
        res_n       = 2'd0;

        if (in_eoi_reg)
        begin
            // end marker: flush / diagnose, then the end token
            res_b.kind   = dts_pkg::KIND_END;
            res_b.start  = pos_reg;
            res_b.length = '0;
            res_b.code   = dts_pkg::ERR_NONE;
            res_a.kind   = dts_pkg::KIND_ERROR;
            res_a.start  = pos_reg;
            res_a.length = '0;
            case (mode_reg)
                dts_pkg::MODE_IDENT, dts_pkg::MODE_NUMBER,
                dts_pkg::MODE_SEP, dts_pkg::MODE_OP:
                begin
                    res_a = pending_res;
                    res_n = 2'd2;
                end
                dts_pkg::MODE_ASSIGN:
                begin
                    res_a.code = dts_pkg::ERR_COLON;
                    res_n      = 2'd2;
                end
                dts_pkg::MODE_COMMENT:
                begin
                    res_a.code = dts_pkg::ERR_COMMENT;
                    res_n      = 2'd2;
                end
                default:
                begin
                    res_a = res_b;
                    res_n = 2'd1;
                end
            endcase
            mode_next   = dts_pkg::MODE_START;
            pos_next    = '0;
            pstart_next = '0;
            plen_next   = '0;
            pkind_next  = dts_pkg::KIND_IDENT;
        end
        else
        begin
            pos_next = pos_reg + dts_pkg::POSITION_BITS'(1);
            // res_b defaults to an error at this byte; code filled per case
            res_b.kind   = dts_pkg::KIND_ERROR;
            res_b.start  = pos_reg;
            res_b.length = '0;
            res_b.code   = dts_pkg::ERR_START;
            case (mode_reg)
                dts_pkg::MODE_START:
                begin
                    if (in_char_reg == dts_pkg::CH_COLON)
                    begin
                        mode_next   = dts_pkg::MODE_ASSIGN;
                        pkind_next  = dts_pkg::KIND_ASSIGN;
                        pstart_next = pos_reg;
                        plen_next   = dts_pkg::LENGTH_BITS'(1);
                    end
                    else if (fs_any.ok)
                    begin
                        mode_next = fs_any.mode;
                        if (fs_any.load)
                        begin
                            pkind_next  = fs_any.kind;
                            pstart_next = pos_reg;
                            plen_next   = dts_pkg::LENGTH_BITS'(1);
                        end
                    end
                    else
                    begin
                        res_a      = res_b;
                        res_n      = 2'd1;
                        mode_next  = dts_pkg::MODE_ERROR;
                    end
                end
                dts_pkg::MODE_IDENT, dts_pkg::MODE_NUMBER:
                begin
                    if ((mode_reg == dts_pkg::MODE_NUMBER) ? num_ext : ident_ext)
                    begin
                        if (plen_reg != dts_pkg::LENGTH_MAX)
                        begin
                            plen_next = plen_reg + dts_pkg::LENGTH_BITS'(1);
                        end
                    end
                    else if (mode_reg == dts_pkg::MODE_IDENT &&
                             in_char_reg == dts_pkg::CH_COLON)
                    begin
                        res_n       = 2'd1;
                        mode_next   = dts_pkg::MODE_ASSIGN;
                        pkind_next  = dts_pkg::KIND_ASSIGN;
                        pstart_next = pos_reg;
                        plen_next   = dts_pkg::LENGTH_BITS'(1);
                    end
                    else if (dts_pkg::is_op(in_char_reg))
                    begin
                        res_n       = 2'd1;
                        mode_next   = dts_pkg::MODE_OP;
                        pkind_next  = dts_pkg::op_kind(in_char_reg);
                        pstart_next = pos_reg;
                        plen_next   = dts_pkg::LENGTH_BITS'(1);
                    end
                    else if (in_char_reg == dts_pkg::CH_LBRACE)
                    begin
                        res_n     = 2'd1;
                        mode_next = dts_pkg::MODE_COMMENT;
                    end
                    else if (in_char_reg == dts_pkg::CH_SEMI ||
                             (mode_reg == dts_pkg::MODE_IDENT &&
                              in_char_reg == dts_pkg::CH_RPAREN))
                    begin
                        res_n       = 2'd1;
                        mode_next   = dts_pkg::MODE_SEP;
                        pkind_next  = dts_pkg::sep_kind(in_char_reg);
                        pstart_next = pos_reg;
                        plen_next   = dts_pkg::LENGTH_BITS'(1);
                    end
                    else if (dts_pkg::is_space(in_char_reg))
                    begin
                        res_n     = 2'd1;
                        mode_next = dts_pkg::MODE_START;
                    end
                    else
                    begin
                        // unfinished token is dropped, only the error goes out
                        res_a      = res_b;
                        res_a.code = (mode_reg == dts_pkg::MODE_NUMBER) ?
                                     dts_pkg::ERR_NUMBER : dts_pkg::ERR_IDENT;
                        res_n      = 2'd1;
                        mode_next  = dts_pkg::MODE_ERROR;
                    end
                end
                dts_pkg::MODE_ASSIGN:
                begin
                    if (in_char_reg == dts_pkg::CH_EQUAL)
                    begin
                        res_a.length = dts_pkg::LENGTH_BITS'(2);
                        plen_next    = dts_pkg::LENGTH_BITS'(2);
                        res_n        = 2'd1;
                        mode_next    = dts_pkg::MODE_START;
                    end
                    else
                    begin
                        res_a      = res_b;
                        res_a.code = dts_pkg::ERR_COLON;
                        res_n      = 2'd1;
                        mode_next  = dts_pkg::MODE_ERROR;
                    end
                end
                dts_pkg::MODE_SEP:
                begin
                    // pending separator goes out first
                    if (fs_any.ok)
                    begin
                        res_n     = 2'd1;
                        mode_next = fs_any.mode;
                        if (fs_any.load)
                        begin
                            pkind_next  = fs_any.kind;
                            pstart_next = pos_reg;
                            plen_next   = dts_pkg::LENGTH_BITS'(1);
                        end
                    end
                    else
                    begin
                        res_b.code = dts_pkg::ERR_SEPARATOR;
                        res_n      = 2'd2;
                        mode_next  = dts_pkg::MODE_ERROR;
                    end
                end
                dts_pkg::MODE_OP:
                begin
                    // two operators in a row, or ';' or a byte that starts nothing after an operator, is an error
                    if (dts_pkg::is_op(in_char_reg) || !fs_nosemi.ok)
                    begin
                        res_b.code = dts_pkg::ERR_OPERATOR;
                        res_n      = 2'd2;
                        mode_next  = dts_pkg::MODE_ERROR;
                    end
                    else
                    begin
                        res_n     = 2'd1;
                        mode_next = fs_nosemi.mode;
                        if (fs_nosemi.load)
                        begin
                            pkind_next  = fs_nosemi.kind;
                            pstart_next = pos_reg;
                            plen_next   = dts_pkg::LENGTH_BITS'(1);
                        end
                    end
                end
                dts_pkg::MODE_COMMENT:
                begin
                    if (in_char_reg == dts_pkg::CH_RBRACE)
                    begin
                        mode_next = dts_pkg::MODE_START;
                    end
                    else if (in_char_reg == dts_pkg::CH_NEWLINE)
                    begin
                        res_a      = res_b;
                        res_a.code = dts_pkg::ERR_COMMENT;
                        res_n      = 2'd1;
                        mode_next  = dts_pkg::MODE_ERROR;
                    end
                end
                default:
                begin
                    // error mode: bytes are dropped, position still advances
                    mode_next = dts_pkg::MODE_ERROR;
                end
            endcase
        end

        // flag the final result of this byte
        if (res_n == 2'd1)
        begin
            res_a.last = 1'b1;
        end
        else if (res_n == 2'd2)
        begin
            res_b.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= dts_pkg::MODE_START;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            pkind_reg  <= dts_pkg::KIND_IDENT;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            pkind_reg  <= pkind_next;
        end
    end

    // ---------------- result queue ----------------
    assign pop = token_chan.valid && token_chan.ready;

    always_ff @(posedge clk)
    begin
        if (step && res_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res_a;
        end
        if (step && res_n == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + dts_pkg::FIFO_PTR_BITS'(1)] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (step)
            begin
                wr_ptr_reg <= wr_ptr_reg + dts_pkg::FIFO_PTR_BITS'(res_n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + dts_pkg::FIFO_PTR_BITS'(1);
            end
            count_reg <= count_reg
                         + (step ? dts_pkg::FIFO_CNT_BITS'(res_n) : '0)
                         - dts_pkg::FIFO_CNT_BITS'(pop);
        end
    end

    assign token_chan.valid        = (count_reg != '0);
    assign token_chan.token_kind   = fifo_mem[rd_ptr_reg].kind;
    assign token_chan.token_start  = fifo_mem[rd_ptr_reg].start;
    assign token_chan.token_length = fifo_mem[rd_ptr_reg].length;
    assign token_chan.error_code   = fifo_mem[rd_ptr_reg].code;
    assign token_chan.last_of_run  = fifo_mem[rd_ptr_reg].last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dts_pkg::FIFO_CNT_BITS'(dts_pkg::FIFO_DEPTH))
        else $error("result queue count over depth");

    a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> count_reg <= dts_pkg::FIFO_CNT_BITS'(dts_pkg::FIFO_DEPTH - 2))
        else $error("scan step without queue room");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_eoi_reg) |=> (mode_reg == dts_pkg::MODE_START && pos_reg == '0))
        else $error("end marker did not reset the automaton");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (token_chan.valid && token_chan.token_kind == dts_pkg::KIND_ERROR)
        |-> (token_chan.error_code != dts_pkg::ERR_NONE && token_chan.token_length == '0))
        else $error("error result without code or with nonzero length");

    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_n == 2'd2) |-> (!res_a.last && res_b.last))
        else $error("last_of_run misplaced on a two-result byte");
`endif

endmodule

@@ dv/dfa_token_scanner_tb.sv @@
`timescale 1ns / 1ps

// Testbench for the byte-serial token scanner.
module dfa_token_scanner_tb;

    typedef logic [dts_pkg::CHAR_BITS-1:0] byte_t;

    // One row of the directed script. typed_count == 0 means the results are
    // taken from the scanner model below; otherwise t0/t1 are the results.
    typedef struct {
        byte_t            ch;
        logic             eoi;
        int               typed_count;
        dts_pkg::result_t t0;
        dts_pkg::result_t t1;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dts_char_if  char_bus ();
    dts_token_if token_bus ();

    dfa_token_scanner uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_chan  (char_bus),
        .token_chan (token_bus)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Scanner model: automaton state, tokens produced by the current byte
    // and the tokens still owed by the DUT, oldest first.
    // ------------------------------------------------------------------
    dts_pkg::mode_t                    scan_mode;
    logic [dts_pkg::POSITION_BITS-1:0] byte_pos;
    logic [dts_pkg::POSITION_BITS-1:0] pend_start;
    logic [dts_pkg::LENGTH_BITS-1:0]   pend_len;
    dts_pkg::kind_t                    pend_kind;

    dts_pkg::result_t step_tokens[$];
    dts_pkg::result_t predicted_tokens[$];

    int  fail_count     = 0;
    int  accepted_items = 0;
    int  burst_left     = 0;
    bit  holdoff_arm    = 1'b0;   // asks the token side for one long stall
    int  holdoff_cycles = 0;      // counted down by the token-side process

    script_row_t script[$];

    function automatic dts_pkg::result_t token_of(dts_pkg::kind_t k, int s, int l,
                                                  dts_pkg::err_t e, bit last);
        dts_pkg::result_t r;
        r.kind   = k;
        r.start  = s[dts_pkg::POSITION_BITS-1:0];
        r.length = l[dts_pkg::LENGTH_BITS-1:0];
        r.code   = e;
        r.last   = last;
        return r;
    endfunction

    // character classes
    function automatic bit letter_byte(byte_t c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == dts_pkg::CH_UNDER;
    endfunction

    function automatic bit digit_byte(byte_t c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit blank_byte(byte_t c);
        return c == dts_pkg::CH_SPACE || c == dts_pkg::CH_TAB || c == dts_pkg::CH_NEWLINE;
    endfunction

    function automatic bit oper_byte(byte_t c);
        return c == dts_pkg::CH_PLUS || c == dts_pkg::CH_MINUS ||
               c == dts_pkg::CH_STAR || c == dts_pkg::CH_SLASH;
    endfunction

    function automatic dts_pkg::kind_t oper_token(byte_t c);
        if (c == dts_pkg::CH_PLUS)
            return dts_pkg::KIND_PLUS;
        if (c == dts_pkg::CH_MINUS)
            return dts_pkg::KIND_MINUS;
        if (c == dts_pkg::CH_STAR)
            return dts_pkg::KIND_STAR;
        return dts_pkg::KIND_SLASH;
    endfunction

    function automatic dts_pkg::kind_t paren_token(byte_t c);
        if (c == dts_pkg::CH_LPAREN)
            return dts_pkg::KIND_LPAREN;
        if (c == dts_pkg::CH_RPAREN)
            return dts_pkg::KIND_RPAREN;
        return dts_pkg::KIND_SEMI;
    endfunction

    function automatic void clear_scanner();
        scan_mode  = dts_pkg::MODE_START;
        byte_pos   = '0;
        pend_start = '0;
        pend_len   = '0;
        pend_kind  = dts_pkg::KIND_IDENT;
    endfunction

    function automatic void open_token(dts_pkg::mode_t m, dts_pkg::kind_t k,
                                       logic [dts_pkg::POSITION_BITS-1:0] p);
        scan_mode  = m;
        pend_kind  = k;
        pend_start = p;
        pend_len   = dts_pkg::LENGTH_BITS'(1);
    endfunction

    function automatic void add_step_token(dts_pkg::result_t r);
        step_tokens.insert(step_tokens.size(), r);
    endfunction

    function automatic void flush_pending();
        add_step_token(token_of(pend_kind, int'(pend_start), int'(pend_len),
                                dts_pkg::ERR_NONE, 1'b0));
    endfunction

    function automatic void raise_error(dts_pkg::err_t e, logic [dts_pkg::POSITION_BITS-1:0] p);
        add_step_token(token_of(dts_pkg::KIND_ERROR, int'(p), 0, e, 1'b0));
        scan_mode = dts_pkg::MODE_ERROR;
    endfunction

    // Entry from start, separator and operator modes; 0 if c starts nothing.
    function automatic bit enter_token(byte_t c, logic [dts_pkg::POSITION_BITS-1:0] p,
                                       bit semi_ok);
        if (letter_byte(c))
            open_token(dts_pkg::MODE_IDENT, dts_pkg::KIND_IDENT, p);
        else if (digit_byte(c))
            open_token(dts_pkg::MODE_NUMBER, dts_pkg::KIND_NUMBER, p);
        else if (c == dts_pkg::CH_LPAREN || c == dts_pkg::CH_RPAREN ||
                 (c == dts_pkg::CH_SEMI && semi_ok))
            open_token(dts_pkg::MODE_SEP, paren_token(c), p);
        else if (oper_byte(c))
            open_token(dts_pkg::MODE_OP, oper_token(c), p);
        else if (c == dts_pkg::CH_LBRACE)
            scan_mode = dts_pkg::MODE_COMMENT;
        else if (blank_byte(c))
            scan_mode = dts_pkg::MODE_START;
        else
            return 1'b0;
        return 1'b1;
    endfunction

    // Advance the model by one transfer; its tokens land in step_tokens.
    function automatic void lex_byte(byte_t c, logic eoi);
        logic [dts_pkg::POSITION_BITS-1:0] p;
        bit                                num;
        bit                                grow;
        step_tokens.delete();
        p = byte_pos;
        if (eoi)
        begin
            case (scan_mode)
                dts_pkg::MODE_IDENT, dts_pkg::MODE_NUMBER,
                dts_pkg::MODE_SEP, dts_pkg::MODE_OP: flush_pending();
                dts_pkg::MODE_ASSIGN:
                    add_step_token(token_of(dts_pkg::KIND_ERROR, int'(p), 0,
                                            dts_pkg::ERR_COLON, 1'b0));
                dts_pkg::MODE_COMMENT:
                    add_step_token(token_of(dts_pkg::KIND_ERROR, int'(p), 0,
                                            dts_pkg::ERR_COMMENT, 1'b0));
                default: ;
            endcase
            add_step_token(token_of(dts_pkg::KIND_END, int'(p), 0, dts_pkg::ERR_NONE, 1'b0));
            clear_scanner();
        end
        else
        begin
            byte_pos = p + dts_pkg::POSITION_BITS'(1);
            case (scan_mode)
                dts_pkg::MODE_START:
                    if (c == dts_pkg::CH_COLON)
                        open_token(dts_pkg::MODE_ASSIGN, dts_pkg::KIND_ASSIGN, p);
                    else if (!enter_token(c, p, 1'b1))
                        raise_error(dts_pkg::ERR_START, p);
                dts_pkg::MODE_IDENT, dts_pkg::MODE_NUMBER:
                begin
                    num  = (scan_mode == dts_pkg::MODE_NUMBER);
                    grow = num ? (digit_byte(c) || c == dts_pkg::CH_DOT ||
                                  c == dts_pkg::CH_LOWER_E ||
                                  c == dts_pkg::CH_PLUS || c == dts_pkg::CH_MINUS)
                               : (digit_byte(c) || letter_byte(c));
                    if (grow)
                    begin
                        if (pend_len != dts_pkg::LENGTH_MAX)
                            pend_len = pend_len + dts_pkg::LENGTH_BITS'(1);
                    end
                    else if (!num && c == dts_pkg::CH_COLON)
                    begin
                        flush_pending();
                        open_token(dts_pkg::MODE_ASSIGN, dts_pkg::KIND_ASSIGN, p);
                    end
                    else if (oper_byte(c))
                    begin
                        flush_pending();
                        open_token(dts_pkg::MODE_OP, oper_token(c), p);
                    end
                    else if (c == dts_pkg::CH_LBRACE)
                    begin
                        flush_pending();
                        scan_mode = dts_pkg::MODE_COMMENT;
                    end
                    else if (c == dts_pkg::CH_SEMI || (!num && c == dts_pkg::CH_RPAREN))
                    begin
                        flush_pending();
                        open_token(dts_pkg::MODE_SEP, paren_token(c), p);
                    end
                    else if (blank_byte(c))
                    begin
                        flush_pending();
                        scan_mode = dts_pkg::MODE_START;
                    end
                    else
                        raise_error(num ? dts_pkg::ERR_NUMBER : dts_pkg::ERR_IDENT, p);
                end
                dts_pkg::MODE_ASSIGN:
                    if (c == dts_pkg::CH_EQUAL)
                    begin
                        pend_len = dts_pkg::LENGTH_BITS'(2);
                        flush_pending();
                        scan_mode = dts_pkg::MODE_START;
                    end
                    else
                        raise_error(dts_pkg::ERR_COLON, p);
                dts_pkg::MODE_SEP:
                begin
                    flush_pending();
                    if (!enter_token(c, p, 1'b1))
                        raise_error(dts_pkg::ERR_SEPARATOR, p);
                end
                dts_pkg::MODE_OP:
                begin
                    // an operator may not follow an operator, nor may ';' or a byte that starts nothing
                    flush_pending();
                    if (oper_byte(c))
                        raise_error(dts_pkg::ERR_OPERATOR, p);
                    else if (!enter_token(c, p, 1'b0))
                        raise_error(dts_pkg::ERR_OPERATOR, p);
                end
                dts_pkg::MODE_COMMENT:
                    if (c == dts_pkg::CH_RBRACE)
                        scan_mode = dts_pkg::MODE_START;
                    else if (c == dts_pkg::CH_NEWLINE)
                        raise_error(dts_pkg::ERR_COMMENT, p);
                default:
                    scan_mode = dts_pkg::MODE_ERROR;   // drop until end marker
            endcase
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Char side: bursts of back-to-back transfers with random gaps. The
    // model is stepped at the edge where the transfer happens.
    // ------------------------------------------------------------------
    task automatic send_item(byte_t ch, logic eoi, int typed_count = 0,
                             dts_pkg::result_t t0 = '0, dts_pkg::result_t t1 = '0);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 30);
            // keep offering while the token side is held off
            if (gap > 0 && holdoff_cycles == 0)
            begin
                char_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        char_bus.valid        <= 1'b1;
        char_bus.input_char   <= ch;
        char_bus.end_of_input <= eoi;
        do
            @(posedge clk);
        while (!char_bus.ready);
        accepted_items++;
        lex_byte(ch, eoi);
        if (typed_count == 0)
        begin
            foreach (step_tokens[i])
                predicted_tokens.insert(predicted_tokens.size(), step_tokens[i]);
        end
        else
        begin
            predicted_tokens.insert(predicted_tokens.size(), t0);
            if (typed_count == 2)
                predicted_tokens.insert(predicted_tokens.size(), t1);
        end
    endtask

    task automatic send_char(byte_t c);
        send_item(c, 1'b0);
    endtask

    // end marker carries a random byte that the scanner must ignore
    task automatic send_end();
        send_item(byte_t'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic void add_row(byte_t ch, logic eoi = 1'b0, int n = 0,
                                    dts_pkg::result_t t0 = '0, dts_pkg::result_t t1 = '0);
        script_row_t r;
        r.ch          = ch;
        r.eoi         = eoi;
        r.typed_count = n;
        r.t0          = t0;
        r.t1          = t1;
        script.insert(script.size(), r);
    endfunction

    // random source text
    function automatic byte_t pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return byte_t'("a" + r);
        if (r < 52)
            return byte_t'("A" + r - 26);
        return dts_pkg::CH_UNDER;
    endfunction

    function automatic byte_t pick_ident_tail();
        if ($urandom_range(0, 62) < 53)
            return pick_letter();
        return byte_t'("0" + $urandom_range(0, 9));
    endfunction

    function automatic byte_t pick_number_tail();
        int r;
        r = $urandom_range(0, 13);
        case (r)
            10:      return dts_pkg::CH_DOT;
            11:      return dts_pkg::CH_LOWER_E;
            12:      return dts_pkg::CH_PLUS;
            13:      return dts_pkg::CH_MINUS;
            default: return byte_t'("0" + r);
        endcase
    endfunction

    function automatic byte_t pick_blank();
        case ($urandom_range(0, 2))
            0:       return dts_pkg::CH_SPACE;
            1:       return dts_pkg::CH_TAB;
            default: return dts_pkg::CH_NEWLINE;
        endcase
    endfunction

    function automatic byte_t pick_comment_byte();
        byte_t c;
        do
            c = byte_t'($urandom_range(0, 255));
        while (c == dts_pkg::CH_RBRACE || c == dts_pkg::CH_NEWLINE);
        return c;
    endfunction

    task automatic send_token();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 25)
        begin
            // mostly short names; now and then one of 251 to 301 bytes, near or past the length limit
            len = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 7);
            send_char(pick_letter());
            repeat (len) send_char(pick_ident_tail());
        end
        else if (sel < 45)
        begin
            send_char(byte_t'("0" + $urandom_range(0, 9)));
            repeat ($urandom_range(0, 6)) send_char(pick_number_tail());
        end
        else if (sel < 52)
        begin
            send_char(dts_pkg::CH_COLON);
            send_char(dts_pkg::CH_EQUAL);
        end
        else if (sel < 64)
        begin
            case ($urandom_range(0, 2))
                0:       send_char(dts_pkg::CH_LPAREN);
                1:       send_char(dts_pkg::CH_RPAREN);
                default: send_char(dts_pkg::CH_SEMI);
            endcase
        end
        else if (sel < 78)
        begin
            case ($urandom_range(0, 3))
                0:       send_char(dts_pkg::CH_PLUS);
                1:       send_char(dts_pkg::CH_MINUS);
                2:       send_char(dts_pkg::CH_STAR);
                default: send_char(dts_pkg::CH_SLASH);
            endcase
        end
        else if (sel < 86)
        begin
            send_char(dts_pkg::CH_LBRACE);
            repeat ($urandom_range(0, 6)) send_char(pick_comment_byte());
            send_char(dts_pkg::CH_RBRACE);
        end
        else
            send_char(pick_blank());
    endtask

    // One statement-like run closed by the end marker. Most runs are
    // well-formed; a few carry a stray byte or stop in an open construct.
    task automatic send_run();
        if ($urandom_range(0, 11) == 0)
        begin
            repeat ($urandom_range(1, 10)) send_char(byte_t'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 14))
            begin
                send_token();
                if ($urandom_range(0, 9) < 7)
                    send_char(pick_blank());
                if ($urandom_range(0, 39) == 0)
                    send_char(byte_t'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 9))
                0: send_char(dts_pkg::CH_COLON);
                1: send_char(dts_pkg::CH_LBRACE);
                2:
                begin
                    send_char(dts_pkg::CH_LBRACE);
                    send_char(dts_pkg::CH_NEWLINE);
                end
                default: ;
            endcase
        end
        send_end();
    endtask

    // ------------------------------------------------------------------
    // Token side: ready follows a style that changes every so often, plus
    // one long hold-off on request so the result queue and input register
    // fill and char_chan.ready drops.
    // ------------------------------------------------------------------
    initial
    begin
        int style;
        int style_left;
        style_left = 0;
        style      = 0;
        token_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            if (holdoff_arm)
            begin
                holdoff_arm    = 1'b0;
                holdoff_cycles = 300;
            end
            if (holdoff_cycles > 0)
            begin
                holdoff_cycles--;
                token_bus.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    0:       token_bus.ready <= 1'b1;
                    1:       token_bus.ready <= ($urandom_range(0, 1) == 1);
                    2:       token_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: token_bus.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every token transfer against the oldest prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        dts_pkg::result_t want;
        if (rst_n && token_bus.valid && token_bus.ready)
        begin
            if (predicted_tokens.size() == 0)
            begin
                $display("%0t ns: token with none pending, expected none, actual kind %h start %h",
                         $time, token_bus.token_kind, token_bus.token_start);
                fail_count++;
            end
            else
            begin
                want = predicted_tokens.pop_front();
                check_field("token_kind",   16'(want.kind),   16'(token_bus.token_kind));
                check_field("token_start",  16'(want.start),  16'(token_bus.token_start));
                check_field("token_length", 16'(want.length), 16'(token_bus.token_length));
                check_field("error_code",   16'(want.code),   16'(token_bus.error_code));
                check_field("last_of_run",  16'(want.last),   16'(token_bus.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int base;
        rst_n                 <= 1'b0;
        char_bus.valid        <= 1'b0;
        char_bus.input_char   <= '0;
        char_bus.end_of_input <= 1'b0;
        clear_scanner();

        // Directed script, offsets count from the last end marker.
        // Non-ASCII byte after a name: name dropped, error only; the byte
        // dropped in error mode still moves the offset.
        add_row("a");
        add_row(8'hFF, 1'b0, 1,
                token_of(dts_pkg::KIND_ERROR, 1, 0, dts_pkg::ERR_IDENT, 1'b1));
        add_row(8'h80);
        add_row(8'h00, 1'b1, 1,
                token_of(dts_pkg::KIND_END, 3, 0, dts_pkg::ERR_NONE, 1'b1));
        // a_9:=(7e-.) : name, assignment, paren, number ended by ')' is an error
        add_row("a");
        add_row(dts_pkg::CH_UNDER);
        add_row("9");
        add_row(dts_pkg::CH_COLON);
        add_row(dts_pkg::CH_EQUAL);
        add_row(dts_pkg::CH_LPAREN);
        add_row("7");
        add_row(dts_pkg::CH_LOWER_E);
        add_row(dts_pkg::CH_MINUS);
        add_row(dts_pkg::CH_DOT);
        add_row(dts_pkg::CH_RPAREN, 1'b0, 1,
                token_of(dts_pkg::KIND_ERROR, 10, 0, dts_pkg::ERR_NUMBER, 1'b1));
        add_row(8'hFF, 1'b1, 1,
                token_of(dts_pkg::KIND_END, 11, 0, dts_pkg::ERR_NONE, 1'b1));
        // {}*/ : empty comment, then operator followed by operator
        add_row(dts_pkg::CH_LBRACE);
        add_row(dts_pkg::CH_RBRACE);
        add_row(dts_pkg::CH_STAR);
        add_row(dts_pkg::CH_SLASH);
        add_row(8'h00, 1'b1, 1,
                token_of(dts_pkg::KIND_END, 4, 0, dts_pkg::ERR_NONE, 1'b1));
        // end marker right after a lone colon
        add_row(dts_pkg::CH_COLON);
        add_row(8'h00, 1'b1, 2,
                token_of(dts_pkg::KIND_ERROR, 1, 0, dts_pkg::ERR_COLON, 1'b0),
                token_of(dts_pkg::KIND_END, 1, 0, dts_pkg::ERR_NONE, 1'b1));
        // end marker inside a comment
        add_row(dts_pkg::CH_LBRACE);
        add_row(8'h00, 1'b1, 2,
                token_of(dts_pkg::KIND_ERROR, 1, 0, dts_pkg::ERR_COMMENT, 1'b0),
                token_of(dts_pkg::KIND_END, 1, 0, dts_pkg::ERR_NONE, 1'b1));
        // newline inside a comment; the first random run starts in error mode
        add_row(dts_pkg::CH_LBRACE);
        add_row(dts_pkg::CH_NEWLINE, 1'b0, 1,
                token_of(dts_pkg::KIND_ERROR, 1, 0, dts_pkg::ERR_COMMENT, 1'b1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_item(script[i].ch, script[i].eoi, script[i].typed_count,
                      script[i].t0, script[i].t1);

        // Random runs; the token side stalls for a long stretch early on.
        holdoff_arm = 1'b1;
        while (accepted_items < 420)
            send_run();

        // one name well past the length limit, then a long number
        send_char("x");
        repeat (299) send_char(pick_ident_tail());
        send_char(dts_pkg::CH_SPACE);
        repeat (260) send_char(byte_t'("0" + $urandom_range(0, 9)));
        send_end();

        base = accepted_items;
        while (accepted_items - base < 300)
            send_run();

        char_bus.valid <= 1'b0;
        while (predicted_tokens.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
